// ===== sv/mcs_pkg.sv =====
// Package for the Markov chain sampler: sizes, command codes and generator step.
`timescale 1ns / 1ps
package mcs_pkg;

  localparam int N_STATES = 16;
  localparam int SYM_W    = (N_STATES > 1) ? $clog2(N_STATES) : 1;
  localparam int ADDR_W   = 2 * SYM_W;
  localparam int DEPTH    = N_STATES * N_STATES;
  localparam int CELL_W   = 32;
  localparam int ROW_W    = 40;
  localparam int ACC_W    = 36;
  localparam int LHS_W    = 64;
  localparam int DRAW_W   = 24;
  localparam int MUL_B_W  = 20;
  localparam int PROD_W   = DRAW_W + MUL_B_W;
  localparam int REM_W    = ROW_W + 1;
  localparam int DIV_STEPS = 17;

  localparam logic [CELL_W-1:0] OBS_UNITS   = 32'd1000;
  localparam logic [CELL_W-1:0] CELL_MAX    = 32'hffff_ffff;
  localparam logic [31:0]       GOLDEN_WORD = 32'h9e37_79b9;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_SAMPLE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // xorshift32 step; a zero word starts from the golden constant
  function automatic logic [31:0] rng_step(input logic [31:0] w);
    logic [31:0] x;
    x = (w == 32'd0) ? GOLDEN_WORD : w;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ===== sv/markov_chain_sampler.sv =====
// Top level of the Markov chain sampler: sequencer, count memory, serial divide and shared multiply.
//
// Usage: one command per input transfer (in_valid/in_stall). Command 0 observes
// a symbol, 1 queries P(next|state) as Q0.16, 2 samples the next state.
// Exactly one result transfer (out_valid/out_stall) follows every command.
// The block takes one command at a time; in_stall is high while it works.
// From accepted input to result on the output register: observe updates one
//   count (none when no transition is added), query runs a
//   seventeen-step restoring divide, sample forms two partial products, then one count
//   table entry a cycle over the row; out-of-range symbols and command 3 go straight out.
// The count table is a 256-entry memory with one registered read port; a valid
// bit per entry makes it read as 1 until first written, so reset is immediate.
// cfg_data written via cfg_valid/cfg_ready reloads the generator word.
// Reset (rst_n low, synchronous) restores all counts, row totals, the previous
// symbol and clears the generator word. If the receiver stalls, the result
// waits in the output register; a further command is still taken, and its result waits in S_OUT.
`timescale 1ns / 1ps
module markov_chain_sampler
  import mcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_symbol,
  input  logic [7:0]  in_next_symbol,
  input  logic        in_seq_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_sampled_state,
  output logic [15:0] out_probability,
  output logic        out_bad_symbol,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_OBS, S_QLD, S_DIV, S_MUL0, S_MUL1, S_MUL2, S_WALK, S_OUT
  } state_t;

  state_t              state_r;
  logic [CELL_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]    cell_vld_r;
  logic [ROW_W-1:0]    row_totals_r [N_STATES];
  logic [CELL_W-1:0]   rd_data_r;
  logic                rd_vld_r;
  logic [7:0]          prev_symbol_r;
  logic                prev_valid_r;
  logic [31:0]         rng_word_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SYM_W-1:0]    row_idx_r;
  logic [SYM_W-1:0]    j_r;
  logic [ROW_W-1:0]    row_r;
  logic [DRAW_W-1:0]   r24_r;
  logic [PROD_W-1:0]   prod_r;
  logic [LHS_W-1:0]    lhs_r;
  logic [ACC_W-1:0]    acc_r;
  logic [REM_W-1:0]    rem_r;
  logic [16:0]         q_r;
  logic [4:0]          step_r;
  logic [7:0]          res_sampled_r;
  logic [15:0]         res_prob_r;
  logic                res_bad_r;
  logic                out_valid_r;
  logic [7:0]          out_sampled_r;
  logic [15:0]         out_prob_r;
  logic                out_bad_r;

  logic [ADDR_W-1:0]   rd_addr;
  logic [CELL_W-1:0]   cell_val;
  logic                obs_ok;
  logic                mem_we;
  logic                sym_ok;
  logic                nxt_ok;
  logic                prev_ok;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [ACC_W-1:0]    acc_nxt;
  logic                hit;
  logic [REM_W-1:0]    div_tmp;
  logic                div_ge;
  logic [16:0]         q_nxt;
  logic [31:0]         rng_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_sampled_state = out_sampled_r;
  assign out_probability   = out_prob_r;
  assign out_bad_symbol    = out_bad_r;

  assign sym_ok  = ({1'b0, in_symbol} < 9'(N_STATES));
  assign nxt_ok  = ({1'b0, in_next_symbol} < 9'(N_STATES));
  assign prev_ok = ({1'b0, prev_symbol_r} < 9'(N_STATES));

  // unwritten cells read as the smoothing value
  assign cell_val = rd_vld_r ? rd_data_r : CELL_W'(1);
  assign obs_ok   = (cell_val <= (CELL_MAX - OBS_UNITS));
  assign mem_we   = (state_r == S_OBS) && obs_ok;

  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        unique case (cmd_t'(in_cmd))
          CMD_OBSERVE: rd_addr = {prev_symbol_r[SYM_W-1:0], in_symbol[SYM_W-1:0]};
          CMD_QUERY:   rd_addr = {in_symbol[SYM_W-1:0], in_next_symbol[SYM_W-1:0]};
          default:     rd_addr = {in_symbol[SYM_W-1:0], SYM_W'(0)};
        endcase
      end
      S_MUL2:  rd_addr = {row_idx_r, SYM_W'(0)};
      S_WALK:  rd_addr = {row_idx_r, j_r + SYM_W'(1)};
      default: rd_addr = addr_r;
    endcase
  end

  // shared multiplier: low then high slice of the row total
  assign mul_b = (state_r == S_MUL0) ? row_r[MUL_B_W-1:0] : row_r[ROW_W-1:MUL_B_W];
  assign mul_p = PROD_W'(r24_r) * PROD_W'(mul_b);

  assign acc_nxt = acc_r + ACC_W'(cell_val);
  assign hit     = (lhs_r <= {{(LHS_W-ACC_W-DRAW_W){1'b0}}, acc_nxt, {DRAW_W{1'b0}}});

  // first step takes the integer bit, later steps shift in zeros
  assign div_tmp = (step_r == 5'd0) ? rem_r : (rem_r << 1);
  assign div_ge  = (div_tmp >= {1'b0, row_r});
  assign q_nxt   = {q_r[15:0], div_ge};

  assign rng_nxt = rng_step(rng_word_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= cell_val + OBS_UNITS;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cell_vld_r    <= '0;
      rd_vld_r      <= 1'b0;
      prev_symbol_r <= '0;
      prev_valid_r  <= 1'b0;
      rng_word_r    <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < N_STATES; i++) begin
        row_totals_r[i] <= ROW_W'(N_STATES);
      end
    end else begin
      rd_vld_r <= cell_vld_r[rd_addr];
      if (cfg_valid && cfg_ready) begin
        rng_word_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            res_sampled_r <= '0;
            res_prob_r    <= '0;
            res_bad_r     <= 1'b0;
            state_r       <= S_OUT;
            unique case (cmd_t'(in_cmd))
              CMD_OBSERVE: begin
                res_bad_r     <= !sym_ok;
                prev_symbol_r <= in_symbol;
                prev_valid_r  <= 1'b1;
                addr_r        <= rd_addr;
                row_idx_r     <= prev_symbol_r[SYM_W-1:0];
                if (!in_seq_start && prev_valid_r && prev_ok && sym_ok) begin
                  state_r <= S_OBS;
                end
              end
              CMD_QUERY: begin
                if (sym_ok && nxt_ok) begin
                  row_r   <= row_totals_r[in_symbol[SYM_W-1:0]];
                  state_r <= S_QLD;
                end else begin
                  res_bad_r <= 1'b1;
                end
              end
              CMD_SAMPLE: begin
                if (sym_ok) begin
                  rng_word_r <= rng_nxt;
                  r24_r      <= rng_nxt[DRAW_W-1:0];
                  row_r      <= row_totals_r[in_symbol[SYM_W-1:0]];
                  row_idx_r  <= in_symbol[SYM_W-1:0];
                  state_r    <= S_MUL0;
                end else begin
                  res_bad_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_OBS: begin
          if (obs_ok) begin
            cell_vld_r[addr_r]      <= 1'b1;
            row_totals_r[row_idx_r] <= row_totals_r[row_idx_r] + ROW_W'(OBS_UNITS);
          end
          state_r <= S_OUT;
        end
        S_QLD: begin
          rem_r   <= REM_W'(cell_val);
          q_r     <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= div_ge ? (div_tmp - {1'b0, row_r}) : div_tmp;
          q_r    <= q_nxt;
          step_r <= step_r + 5'd1;
          if (step_r == 5'(DIV_STEPS - 1)) begin
            res_prob_r <= q_nxt[16] ? 16'hffff : q_nxt[15:0];
            state_r    <= S_OUT;
          end
        end
        S_MUL0: begin
          prod_r  <= mul_p;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          lhs_r   <= LHS_W'(prod_r);
          prod_r  <= mul_p;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          lhs_r   <= lhs_r + (LHS_W'(prod_r) << MUL_B_W);
          acc_r   <= '0;
          j_r     <= '0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          acc_r <= acc_nxt;
          j_r   <= j_r + SYM_W'(1);
          if (hit || (j_r == SYM_W'(N_STATES - 1))) begin
            res_sampled_r <= hit ? 8'(j_r) : 8'(N_STATES - 1);
            state_r       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_sampled_r <= res_sampled_r;
            out_prob_r    <= res_prob_r;
            out_bad_r     <= res_bad_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
